>>> sv/ddpf_pkg.sv
// ---------------------------------------------------------------------------
// ddpf_pkg: shared constants and helpers of the damped dispersion pair force
// Table geometry, unit latencies, register and command codes, saturation.
// ---------------------------------------------------------------------------
`default_nettype none

package ddpf_pkg;

    localparam int TYPE_COUNT = 16;
    localparam int TBL_DEPTH  = TYPE_COUNT * TYPE_COUNT;
    localparam int TBL_AW     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    localparam int MUL_LAT    = 2;
    localparam int DIV_STEPS  = 64;
    localparam int DIV_LAT    = DIV_STEPS + 1;
    localparam int SQRT_STEPS = 64;
    localparam int SQRT_LAT   = SQRT_STEPS + 1;

    localparam logic [0:0] REG_CUTOFF = 1'b0;
    localparam logic [0:0] REG_MODE   = 1'b1;

    localparam logic [1:0] MODE_A3  = 2'd0;
    localparam logic [1:0] MODE_A6  = 2'd1;
    localparam logic [1:0] MODE_A12 = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PAIR = 1'b1;

    // clamp a shifted product to 64 bits
    function automatic logic [63:0] sat64(input logic [127:0] v);
        sat64 = (v[127:64] != 64'd0) ? '1 : v[63:0];
    endfunction

    // magnitude and sign to saturated 48-bit two's complement
    function automatic logic [47:0] sat_out(input logic [63:0] mag, input logic neg);
        logic [63:0] m;
        if (neg) begin
            m = (mag > 64'h8000_0000_0000) ? 64'h8000_0000_0000 : mag;
            sat_out = 48'(64'd0 - m);
        end else begin
            m = (mag > 64'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : mag;
            sat_out = m[47:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/ddpf_mul64.sv
// ---------------------------------------------------------------------------
// ddpf_mul64: pipelined 64 x 64 unsigned multiplier
// Four 32 x 32 partial products in the first stage, summed in the second.
// ---------------------------------------------------------------------------
`default_nettype none

module ddpf_mul64 (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic      [127:0] p
);

    logic [63:0]  pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [127:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_ll_reg <= 64'(a[31:0]) * 64'(b[31:0]);
            pp_lh_reg <= 64'(a[31:0]) * 64'(b[63:32]);
            pp_hl_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            pp_hh_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            p_reg     <= 128'(pp_ll_reg) + (128'(pp_lh_reg) << 32)
                       + (128'(pp_hl_reg) << 32) + (128'(pp_hh_reg) << 64);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> sv/ddpf_div.sv
// ---------------------------------------------------------------------------
// ddpf_div: pipelined 128 / 64 restoring divider
// One quotient bit per stage; an overflowing or zero-divisor quotient is all ones.
// ---------------------------------------------------------------------------
`default_nettype none

module ddpf_div import ddpf_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [127:0] num,
    input  wire logic [63:0]  den,
    output logic      [63:0]  quo
);

    logic [63:0] rem_reg [0:DIV_STEPS];
    logic [63:0] lo_reg  [0:DIV_STEPS];
    logic [63:0] dvs_reg [0:DIV_STEPS];
    logic [63:0] quo_reg [0:DIV_STEPS];
    logic        sat_reg [0:DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num[127:64];
            lo_reg[0]  <= num[63:0];
            dvs_reg[0] <= den;
            quo_reg[0] <= '0;
            sat_reg[0] <= (den == 64'd0) || (num[127:64] >= den);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [64:0] trial;
        logic        take;

        assign trial = {rem_reg[k], lo_reg[k][63]};
        assign take  = trial >= {1'b0, dvs_reg[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= take ? 64'(trial - {1'b0, dvs_reg[k]}) : trial[63:0];
                lo_reg[k+1]  <= lo_reg[k] << 1;
                dvs_reg[k+1] <= dvs_reg[k];
                quo_reg[k+1] <= {quo_reg[k][62:0], take};
                sat_reg[k+1] <= sat_reg[k];
            end
        end
    end

    assign quo = sat_reg[DIV_STEPS] ? '1 : quo_reg[DIV_STEPS];

endmodule

`default_nettype wire

>>> sv/ddpf_sqrt.sv
// ---------------------------------------------------------------------------
// ddpf_sqrt: pipelined 128-bit integer square root
// Digit-by-digit, one root bit per stage, result is the floor of the root.
// ---------------------------------------------------------------------------
`default_nettype none

module ddpf_sqrt import ddpf_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [127:0] x,
    output logic      [63:0]  root
);

    logic [65:0]  rem_reg  [0:SQRT_STEPS];
    logic [63:0]  root_reg [0:SQRT_STEPS];
    logic [127:0] x_reg    [0:SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            x_reg[0]    <= x;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [67:0] cur;
        logic [67:0] trial;
        logic        take;

        assign cur   = {rem_reg[k], x_reg[k][127:126]};
        assign trial = {2'b00, root_reg[k], 2'b01};
        assign take  = cur >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= take ? 66'(cur - trial) : cur[65:0];
                root_reg[k+1] <= {root_reg[k][62:0], take};
                x_reg[k+1]    <= x_reg[k] << 2;
            end
        end
    end

    assign root = root_reg[SQRT_STEPS];

endmodule

`default_nettype wire

>>> sv/ddpf_table.sv
// ---------------------------------------------------------------------------
// ddpf_table: per type pair coefficient memory
// One write port, one registered read port holding c6 and damping radius.
// ---------------------------------------------------------------------------
`default_nettype none

module ddpf_table import ddpf_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [TBL_AW-1:0] wr_addr,
    input  wire logic [31:0]       wr_disp,
    input  wire logic [23:0]       wr_rad,
    input  wire logic              rd_en,
    input  wire logic [TBL_AW-1:0] rd_addr,
    output logic      [31:0]       rd_disp,
    output logic      [23:0]       rd_rad
);

    logic [55:0] mem [0:TBL_DEPTH-1];
    logic [55:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_rad, wr_disp};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_disp = rd_reg[31:0];
    assign rd_rad  = rd_reg[55:32];

endmodule

`default_nettype wire

>>> sv/damped_dispersion_pair_force_unit.sv
// ---------------------------------------------------------------------------
// damped_dispersion_pair_force_unit: damped dispersion pair force pipeline
// Coefficient table plus pipelined force and energy datapath.
// ---------------------------------------------------------------------------
// Takes one word per cycle unless stalled, load words and pair words alike, and
// gives a result for each accepted pair word; load words write the coefficient
// table and give no result. The latency is set by the chain of a 64-step square
// root and three dependent 64-step dividers, with pipelined multipliers between
// them. The whole pipeline holds while a finished result waits on m_tready.
// Table entries read before they are loaded give undefined results. The user
// writes configuration only while no pair is in flight; this is not enforced.
`default_nettype none

module damped_dispersion_pair_force_unit import ddpf_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // type_first, type_second, pos_first_x/y/z, pos_second_x/y/z,
    // load_dispersion, load_radius
    input  wire logic [255:0] s_tdata,
    // cmd
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // force_x, force_y, force_z, pair_energy
    output logic      [191:0] m_tdata,
    // in_range
    output logic      [0:0]   m_tuser,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_addr,
    input  wire logic [47:0]  cfg_wdata
);

    localparam int K_SQ = 1;
    localparam int K_R2 = 2;
    localparam int K_M1 = K_R2 + MUL_LAT + 1;
    localparam int K_M2 = K_M1 + MUL_LAT + 1;
    localparam int K_M3 = K_M2 + MUL_LAT + 1;
    localparam int K_S  = K_M3 + SQRT_LAT + 1;
    localparam int K_M4 = K_S + MUL_LAT + 1;
    localparam int K_D1 = K_M4 + DIV_LAT + 1;
    localparam int K_M5 = K_D1 + MUL_LAT + 1;
    localparam int K_D2 = K_M5 + DIV_LAT + 1;
    localparam int K_M6 = K_D2 + MUL_LAT + 1;
    localparam int LAST = K_M6 + DIV_LAT;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic              far;
        logic              live;
        logic [2:0]        neg;
        logic [2:0][27:0]  ad;
        logic [31:0]       c6;
        logic [23:0]       rad;
        logic [47:0]       rad2;
        logic [2:0][55:0]  sq;
        logic [57:0]       r2;
        logic [63:0]       r4;
        logic [63:0]       r6;
        logic [63:0]       rad3;
        logic [63:0]       rad4;
        logic [63:0]       rad6;
        logic [63:0]       root;
        logic [63:0]       den;
        logic [63:0]       a;
        logic [63:0]       emag;
        logic [2:0][127:0] num;
    } item_t;

    item_t pipe_reg  [0:LAST];
    item_t pipe_next [0:LAST];

    logic [47:0] cutoff_reg;
    logic [1:0]  mode_reg;
    logic        m_tvalid_reg;
    logic [47:0] fx_reg, fy_reg, fz_reg, energy_reg;
    logic        in_range_reg;

    logic en, accept;
    logic m0, m12, six;

    // input word fields
    logic [3:0]  row, col;
    logic [31:0] pf [3];
    logic [31:0] ps [3];
    logic        in_ok;
    logic [TBL_AW-1:0] in_idx;
    logic [32:0] dv [3];
    logic [32:0] av [3];

    logic [31:0] rd_disp;
    logic [23:0] rd_rad;

    logic [127:0] p1a, p1b, p1c, p2a, p2b, p3a, p3b, p4a, p4b, p5;
    logic [127:0] p6 [3];
    logic [63:0]  sq_root, q1a, q1e, q2a, q2e;
    logic [63:0]  q3 [3];
    logic [128:0] sum6;
    logic [64:0]  den6;
    logic [63:0]  r3;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    assign m0  = (mode_reg == MODE_A3);
    assign m12 = (mode_reg == MODE_A12);
    assign six = !m0 && !m12;

    assign row   = s_tdata[3:0];
    assign col   = s_tdata[7:4];
    assign pf[0] = s_tdata[39:8];
    assign pf[1] = s_tdata[71:40];
    assign pf[2] = s_tdata[103:72];
    assign ps[0] = s_tdata[135:104];
    assign ps[1] = s_tdata[167:136];
    assign ps[2] = s_tdata[199:168];

    assign in_ok  = (7'(row) < 7'(TYPE_COUNT)) && (7'(col) < 7'(TYPE_COUNT));
    assign in_idx = TBL_AW'(int'(row) * TYPE_COUNT + int'(col));

    for (genvar k = 0; k < 3; k++) begin : g_diff
        assign dv[k] = {pf[k][31], pf[k]} - {ps[k][31], ps[k]};
        assign av[k] = dv[k][32] ? 33'(33'd0 - dv[k]) : dv[k];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= '0;
            mode_reg   <= MODE_A6;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CUTOFF: cutoff_reg <= cfg_wdata;
                REG_MODE:   mode_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    ddpf_table u_table (
        .aclk    (aclk),
        .wr_en   (accept && s_tuser[0] == CMD_LOAD && in_ok),
        .wr_addr (in_idx),
        .wr_disp (s_tdata[231:200]),
        .wr_rad  (s_tdata[255:232]),
        .rd_en   (en),
        .rd_addr (in_idx),
        .rd_disp (rd_disp),
        .rd_rad  (rd_rad)
    );

    // r4, rad4, rad3
    ddpf_mul64 u_m1a (.aclk(aclk), .en(en), .a(64'(pipe_reg[K_R2].r2)),
                      .b(64'(pipe_reg[K_R2].r2)), .p(p1a));
    ddpf_mul64 u_m1b (.aclk(aclk), .en(en), .a(64'(pipe_reg[K_R2].rad2)),
                      .b(64'(pipe_reg[K_R2].rad2)), .p(p1b));
    ddpf_mul64 u_m1c (.aclk(aclk), .en(en), .a(64'(pipe_reg[K_R2].rad2)),
                      .b(64'(pipe_reg[K_R2].rad)), .p(p1c));
    // r6, rad6
    ddpf_mul64 u_m2a (.aclk(aclk), .en(en), .a(pipe_reg[K_M1].r4),
                      .b(64'(pipe_reg[K_M1].r2)), .p(p2a));
    ddpf_mul64 u_m2b (.aclk(aclk), .en(en), .a(pipe_reg[K_M1].rad4),
                      .b(64'(pipe_reg[K_M1].rad2)), .p(p2b));
    // squares for the a=12 root
    ddpf_mul64 u_m3a (.aclk(aclk), .en(en), .a(pipe_reg[K_M2].r6),
                      .b(pipe_reg[K_M2].r6), .p(p3a));
    ddpf_mul64 u_m3b (.aclk(aclk), .en(en), .a(pipe_reg[K_M2].rad6),
                      .b(pipe_reg[K_M2].rad6), .p(p3b));

    ddpf_sqrt u_sqrt (.aclk(aclk), .en(en), .x(pipe_reg[K_M3].num[0]), .root(sq_root));

    // r3 and first numerator
    ddpf_mul64 u_m4a (.aclk(aclk), .en(en), .a(64'(pipe_reg[K_S].r2)),
                      .b(pipe_reg[K_S].root), .p(p4a));
    ddpf_mul64 u_m4b (.aclk(aclk), .en(en),
                      .a(64'(pipe_reg[K_S].c6) * 64'd6),
                      .b(m0 ? (pipe_reg[K_S].root << 28) : pipe_reg[K_S].r4),
                      .p(p4b));

    ddpf_div u_d1a (.aclk(aclk), .en(en), .num(pipe_reg[K_M4].num[0]),
                    .den(pipe_reg[K_M4].den), .quo(q1a));
    ddpf_div u_d1e (.aclk(aclk), .en(en),
                    .num(m0 ? (128'(pipe_reg[K_M4].c6) << 48)
                            : (128'(pipe_reg[K_M4].c6) << 24)),
                    .den(pipe_reg[K_M4].den), .quo(q1e));

    ddpf_mul64 u_m5 (.aclk(aclk), .en(en), .a(pipe_reg[K_D1].a),
                     .b(m0 ? (64'd1 << 36) : pipe_reg[K_D1].r6), .p(p5));

    ddpf_div u_d2a (.aclk(aclk), .en(en), .num(pipe_reg[K_M5].num[0]),
                    .den(pipe_reg[K_M5].den), .quo(q2a));
    ddpf_div u_d2e (.aclk(aclk), .en(en), .num(pipe_reg[K_M5].num[1]),
                    .den(pipe_reg[K_M5].den), .quo(q2e));

    for (genvar k = 0; k < 3; k++) begin : g_axis
        ddpf_mul64 u_m6 (.aclk(aclk), .en(en), .a(pipe_reg[K_D2].a),
                         .b(64'(pipe_reg[K_D2].ad[k])), .p(p6[k]));
        ddpf_div u_d3 (.aclk(aclk), .en(en), .num(pipe_reg[K_M6].num[k]),
                       .den(pipe_reg[K_M6].den), .quo(q3[k]));
    end

    assign sum6 = {1'b0, p3a} + {1'b0, p3b};
    assign den6 = {1'b0, pipe_reg[K_S + MUL_LAT].r6} + {1'b0, pipe_reg[K_S + MUL_LAT].rad6};
    assign r3   = sat64(p4a >> 28);

    always_comb begin
        pipe_next[0]       = '0;
        pipe_next[0].valid = accept && s_tuser[0] == CMD_PAIR;
        pipe_next[0].ok    = in_ok;
        for (int k = 0; k < 3; k++) begin
            pipe_next[0].neg[k] = !dv[k][32] && (dv[k] != 33'd0);
            pipe_next[0].ad[k]  = av[k][27:0];
            if (av[k][32:28] != 5'd0) begin
                pipe_next[0].far = 1'b1;
            end
        end

        for (int i = 1; i <= LAST; i++) begin
            pipe_next[i] = pipe_reg[i-1];
        end

        pipe_next[K_SQ].c6   = rd_disp;
        pipe_next[K_SQ].rad  = rd_rad;
        pipe_next[K_SQ].rad2 = 48'(rd_rad) * 48'(rd_rad);
        for (int k = 0; k < 3; k++) begin
            pipe_next[K_SQ].sq[k] = 56'(pipe_reg[K_SQ-1].ad[k]) * 56'(pipe_reg[K_SQ-1].ad[k]);
        end

        pipe_next[K_R2].r2 = 58'(pipe_reg[K_R2-1].sq[0]) + 58'(pipe_reg[K_R2-1].sq[1])
                           + 58'(pipe_reg[K_R2-1].sq[2]);
        pipe_next[K_R2].live = pipe_reg[K_R2-1].valid && pipe_reg[K_R2-1].ok
                             && !pipe_reg[K_R2-1].far
                             && (pipe_next[K_R2].r2 < {2'b00, cutoff_reg, 8'd0});

        pipe_next[K_M1].r4   = sat64(p1a >> 48);
        pipe_next[K_M1].rad4 = p1b[95:32];
        pipe_next[K_M1].rad3 = p1c[79:16];

        pipe_next[K_M2].r6   = sat64(p2a >> 56);
        pipe_next[K_M2].rad6 = p2b[111:48];

        // a=3 takes the root of r2, a=12 the root of r6^2 + R6^2
        pipe_next[K_M3].num[0] = m0 ? 128'(pipe_reg[K_M3-1].r2)
                                    : (sum6[128] ? '1 : sum6[127:0]);

        pipe_next[K_S].root = sq_root;

        pipe_next[K_M4].num[0] = p4b;
        if (m0) begin
            pipe_next[K_M4].den = r3 + pipe_reg[K_M4-1].rad3;
        end else if (m12) begin
            pipe_next[K_M4].den = pipe_reg[K_M4-1].root;
        end else begin
            pipe_next[K_M4].den = den6[64] ? '1 : den6[63:0];
        end

        pipe_next[K_D1].a    = q1a;
        pipe_next[K_D1].emag = q1e;

        pipe_next[K_M5].num[0] = p5;
        pipe_next[K_M5].num[1] = 128'(pipe_reg[K_M5-1].emag) << 24;

        pipe_next[K_D2].a    = six ? pipe_reg[K_D2-1].a : q2a;
        pipe_next[K_D2].emag = m0 ? q2e : pipe_reg[K_D2-1].emag;

        for (int k = 0; k < 3; k++) begin
            pipe_next[K_M6].num[k] = m0 ? p6[k] : (p6[k] >> 12);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= LAST; i++) begin
                pipe_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            pipe_reg <= pipe_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= pipe_reg[LAST].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (pipe_reg[LAST].live) begin
                fx_reg     <= sat_out(q3[0], pipe_reg[LAST].neg[0]);
                fy_reg     <= sat_out(q3[1], pipe_reg[LAST].neg[1]);
                fz_reg     <= sat_out(q3[2], pipe_reg[LAST].neg[2]);
                energy_reg <= sat_out(pipe_reg[LAST].emag, 1'b1);
            end else begin
                fx_reg     <= '0;
                fy_reg     <= '0;
                fz_reg     <= '0;
                energy_reg <= '0;
            end
            in_range_reg <= pipe_reg[LAST].live;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {energy_reg, fz_reg, fy_reg, fx_reg};
    assign m_tuser  = in_range_reg;

endmodule

`default_nettype wire
